// ----- hdl/mpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_pkg: shared types and constants for the max pool with argmax block
// Register indexes, configuration record and controller/datapath signals.
// ----------------------------------------------------------------------------
package mpa_pkg;

  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_POOL     = 8;
  localparam int DEF_DATA_WIDTH   = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y      = 3'd6;

  // Raw register contents at their port widths
  typedef struct packed {
    logic [6:0] image_width;
    logic [6:0] image_height;
    logic [4:0] channel_count;
    logic [3:0] pool_width;
    logic [3:0] pool_height;
    logic [3:0] stride_x;
    logic [3:0] stride_y;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch input item and write it
    logic scan_start; // clear running max, start window read
    logic scan_step;  // issue next window read
    logic out_load;   // move result to output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;       // accepted item completes a window
    logic scan_done;  // last window read issued
    logic cmp_done;   // last comparison finished
  } dp_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DRN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

endpackage

// ----- hdl/mpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_ctrl: sequencer for the pooling block
// Accepts a request, runs the window scan and hands over the result.
// ----------------------------------------------------------------------------
module mpa_ctrl import mpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    out_busy,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = ST_DRN;
      end
      ST_DRN: begin
        if (sts.cmp_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_IDLE && in_valid && sts.emit) begin
      cmd.scan_start = 1'b1;
      state_nxt = ST_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- hdl/mpa_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_dpath: position tracking, line store and window max search
// One line store read per cycle; compare runs in the cycle after the read.
// ----------------------------------------------------------------------------
module mpa_dpath import mpa_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_POOL     = DEF_MAX_POOL,
  parameter int DATA_WIDTH   = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_t                         cfg,
  input  dp_cmd_t                      cmd,
  output dp_sts_t                      sts,
  input  logic signed [DATA_WIDTH-1:0] in_sample,
  input  logic                         in_sos,
  output logic signed [DATA_WIDTH-1:0] res_max,
  output logic [5:0]                   res_index,
  output logic [5:0]                   res_row,
  output logic [5:0]                   res_col,
  output logic [3:0]                   res_chan,
  output logic                         res_last
);

  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int PCW = $clog2(MAX_POOL + 1);
  localparam int DEPTH = MAX_POOL * MAX_WIDTH * MAX_CHANNELS;
  localparam int AW = $clog2(DEPTH);
  localparam int RX = RW + 1;
  localparam int CX = CW + 1;
  localparam int HX = HW + 1;

  // Clamped configuration
  logic [CX-1:0]  cw_w;
  logic [RX-1:0]  ch_h;
  logic [HX-1:0]  cc;
  logic [PCW-1:0] ppw, pph;
  logic [3:0]     csx, csy;

  function automatic logic [10:0] clampv(input logic [6:0] v, input int hi);
    logic [10:0] r;
    r = {4'd0, v};
    if (v == 7'd0) r = 11'd1;
    else if (int'(v) > hi) r = 11'(hi);
    return r;
  endfunction

  assign cw_w = CX'(clampv(cfg.image_width, MAX_WIDTH));
  assign ch_h = RX'(clampv(cfg.image_height, MAX_HEIGHT));
  assign cc   = HX'(clampv({2'd0, cfg.channel_count}, MAX_CHANNELS));
  assign ppw  = PCW'(clampv({3'd0, cfg.pool_width}, MAX_POOL));
  assign pph  = PCW'(clampv({3'd0, cfg.pool_height}, MAX_POOL));
  assign csx  = 4'(clampv({3'd0, cfg.stride_x}, 8));
  assign csy  = 4'(clampv({3'd0, cfg.stride_y}, 8));

  // Position and window phase counters (phase replaces the stride modulo)
  logic [RX-1:0] row_r, row_nxt;
  logic [CX-1:0] col_r, col_nxt;
  logic [HX-1:0] chn_r, chn_nxt;
  logic [3:0]    phy_r, phx_r, phy_nxt, phx_nxt;
  logic [5:0]    oy_r, ox_r;
  logic [RX-1:0] r;
  logic [CX-1:0] c;
  logic [HX-1:0] h;
  logic [3:0]    py, px;
  logic [5:0]    oy, ox;
  logic          inb, rok, cok, emit;

  always_comb begin
    r = in_sos ? '0 : row_r;
    c = in_sos ? '0 : col_r;
    h = in_sos ? '0 : chn_r;
    py = in_sos ? '0 : phy_r;
    px = in_sos ? '0 : phx_r;
    oy = in_sos ? '0 : oy_r;
    ox = in_sos ? '0 : ox_r;
    inb = (r < ch_h) && (c < cw_w) && (h < cc);
    rok = (32'(r) + 1 >= 32'(pph));
    cok = (32'(c) + 1 >= 32'(ppw));
    emit = inb && rok && cok && py == 4'd0 && px == 4'd0;
    row_nxt = r; col_nxt = c; chn_nxt = h + 1'b1;
    phy_nxt = py; phx_nxt = px;
    if (chn_nxt >= cc) begin
      chn_nxt = '0;
      col_nxt = c + 1'b1;
      if (cok) begin
        if (px + 1 >= csx) phx_nxt = '0;
        else phx_nxt = px + 1'b1;
      end
      if (col_nxt >= cw_w) begin
        col_nxt = '0; phx_nxt = '0;
        row_nxt = r + 1'b1;
        if (rok) begin
          if (py + 1 >= csy) phy_nxt = '0;
          else phy_nxt = py + 1'b1;
        end
        if (row_nxt >= ch_h) begin
          row_nxt = '0; phy_nxt = '0;
        end
      end
    end
  end

  // Window counters: count emitted windows per row/col
  logic [5:0] oyn, oxn;
  always_comb begin
    oyn = oy; oxn = ox;
    if (chn_nxt == '0 && cok && px + 1 >= csx && h + 1 >= cc) oxn = ox + 6'd1;
    if (col_nxt == '0 && chn_nxt == '0 && h + 1 >= cc) begin
      oxn = '0;
      if (rok && py + 1 >= csy) oyn = oy + 6'd1;
      if (row_nxt == '0) oyn = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0; chn_r <= '0;
      phy_r <= '0; phx_r <= '0; oy_r <= '0; ox_r <= '0;
    end else if (cmd.accept) begin
      row_r <= row_nxt; col_r <= col_nxt; chn_r <= chn_nxt;
      phy_r <= phy_nxt; phx_r <= phx_nxt;
      oy_r <= oyn; ox_r <= oxn;
    end
  end

  // Line store
  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]   waddr, raddr;
  logic [PW-1:0]   rrow_w;
  logic signed [DATA_WIDTH-1:0] rdata_r;

  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] rr,
                                            input logic [CW-1:0] cc_i,
                                            input logic [HW-1:0] hh);
    return AW'((32'(rr) * MAX_WIDTH + 32'(cc_i)) * MAX_CHANNELS + 32'(hh));
  endfunction

  assign waddr = addr_of(PW'(32'(r) % MAX_POOL), CW'(c), HW'(h));

  // Scan state
  logic [RX-1:0] y0_r;
  logic [CX-1:0] x0_r;
  logic [HW-1:0] sch_r;
  logic [PCW-1:0] yi_r, xi_r;
  logic [5:0]    idx_r;
  logic          rv_r, lastrd_r;
  logic [5:0]    ridx_r;
  logic [RX-1:0] ry;
  logic          scan_done;

  assign ry = y0_r + RX'(yi_r);
  assign rrow_w = PW'(32'(ry) % MAX_POOL);
  assign raddr = addr_of(rrow_w, CW'(x0_r + CX'(xi_r)), sch_r);
  assign scan_done = (32'(yi_r) + 1 == 32'(pph)) && (32'(xi_r) + 1 == 32'(ppw));

  always_ff @(posedge clk) begin
    if (cmd.accept && inb) mem[waddr] <= in_sample;
    rdata_r <= mem[raddr];
  end

  logic signed [DATA_WIDTH-1:0] best_r;
  logic [5:0] bidx_r;
  logic cmp_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0; lastrd_r <= 1'b0; cmp_done_r <= 1'b0;
    end else begin
      rv_r <= cmd.scan_step;
      lastrd_r <= cmd.scan_step && scan_done;
      cmp_done_r <= lastrd_r;
    end
    if (cmd.scan_start) begin
      y0_r <= RX'(32'(r) + 1 - 32'(pph));
      x0_r <= CX'(32'(c) + 1 - 32'(ppw));
      sch_r <= HW'(h);
      yi_r <= '0; xi_r <= '0; idx_r <= '0;
      best_r <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      bidx_r <= '0;
      res_row <= oy; res_col <= ox; res_chan <= 4'(h);
      // last window row/column: the next origin would no longer fit
      res_last <= (32'(r) + 32'(csy) >= 32'(ch_h)) &&
                  (32'(c) + 32'(csx) >= 32'(cw_w)) &&
                  (32'(h) + 1 == 32'(cc));
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 6'd1;
      if (32'(xi_r) + 1 == 32'(ppw)) begin
        xi_r <= '0; yi_r <= yi_r + 1'b1;
      end else xi_r <= xi_r + 1'b1;
    end
    ridx_r <= idx_r;
    if (rv_r && rdata_r > best_r) begin
      best_r <= rdata_r; bidx_r <= ridx_r;
    end
  end

  assign res_max = best_r;
  assign res_index = bidx_r;
  assign sts.emit = emit;
  assign sts.scan_done = scan_done;
  assign sts.cmp_done = cmp_done_r;

endmodule

// ----- hdl/max_pool_with_argmax.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_with_argmax: streamed 2D max pooling with first-max index
// Usage:
//   Input samples arrive in row, column, channel order on in_valid/in_stall;
//   in_start_of_image restarts the position. Every sample is stored; a sample
//   that closes a pooling window starts a scan of that window.
//   A sample that closes no window is taken without stalling the input. A
//   closing sample stalls the input until its result is loaded: the scan reads
//   one window element per cycle through the single line store read port.
//   Results leave on out_valid/out_stall from an output register; while it
//   is stalled the next non-closing samples are still taken.
//   Configuration is written on cfg_valid/cfg_ready (always ready); the user
//   must write only while the block is idle (not enforced). Reset restores
//   defaults and position zero, not the line store (undefined until written).
// ----------------------------------------------------------------------------
module max_pool_with_argmax import mpa_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_POOL     = DEF_MAX_POOL,
  parameter int DATA_WIDTH   = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_sample,
  input  logic                         in_start_of_image,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_max_value,
  output logic [5:0]                   out_window_index,
  output logic [5:0]                   out_out_row,
  output logic [5:0]                   out_out_col,
  output logic [3:0]                   out_channel,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [6:0]                   cfg_data
);

  cfg_t cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [DATA_WIDTH-1:0] res_max;
  logic [5:0] res_index, res_row, res_col;
  logic [3:0] res_chan;
  logic res_last, out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{7'd8, 7'd8, 5'd1, 4'd2, 4'd2, 4'd2, 4'd2};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  cfg_r.image_height  <= cfg_data;
        REG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_data[4:0];
        REG_POOL_WIDTH:    cfg_r.pool_width    <= cfg_data[3:0];
        REG_POOL_HEIGHT:   cfg_r.pool_height   <= cfg_data[3:0];
        REG_STRIDE_X:      cfg_r.stride_x      <= cfg_data[3:0];
        REG_STRIDE_Y:      cfg_r.stride_y      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  mpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid_r && out_stall), .cmd(cmd), .sts(sts)
  );

  mpa_dpath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_POOL(MAX_POOL), .DATA_WIDTH(DATA_WIDTH)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd(cmd), .sts(sts),
    .in_sample(in_sample), .in_sos(in_start_of_image),
    .res_max(res_max), .res_index(res_index), .res_row(res_row),
    .res_col(res_col), .res_chan(res_chan), .res_last(res_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
    if (cmd.out_load) begin
      out_max_value <= res_max; out_window_index <= res_index;
      out_out_row <= res_row; out_out_col <= res_col;
      out_channel <= res_chan; out_last <= res_last;
    end
  end
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // Never load a new result over one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load) else $error("result overwritten");
  // No input taken while a window scan runs
  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> in_stall) else $error("input taken during scan");
  // A finished comparison leads to a load attempt
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.cmp_done && !out_valid_r) |=> cmd.out_load) else $error("result lost");
`endif

endmodule
